// ===== rtl/byte_histogram_with_column_readout_defines.svh =====
// Assertion macros for the byte histogram RTL.
// Used by byte_histogram_with_column_readout.sv; expects i_clk and i_rst_n in scope.
`ifndef BYTE_HISTOGRAM_WITH_COLUMN_READOUT_DEFINES_SVH
`define BYTE_HISTOGRAM_WITH_COLUMN_READOUT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define BH_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bh_pkg.sv =====
// Shared types and constants for the byte histogram block.
// No dependencies; imported by byte_histogram_with_column_readout.
`default_nettype none

package bh_pkg;

    // Fixed field widths
    localparam int OP_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_DATA_W  = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int NUM_CODES   = 256;
    localparam int HALF_CODES  = 128;

    // Parameter defaults
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int COLUMNS_DEF     = 8;

    // Input word kinds
    typedef enum logic [OP_W-1:0] {
        OP_COUNT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MODE = 1'b0,
        CFG_TABLE_MODE = 1'b1
    } t_cfg_idx;

    // Range codes (any other code selects all 256 codes)
    localparam logic [1:0] RANGE_LOW  = 2'd0;
    localparam logic [1:0] RANGE_HIGH = 2'd1;

    // What the second pipeline stage holds
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_COUNT,
        KIND_READ,
        KIND_CLEAR
    } t_kind;

endpackage

`default_nettype wire

// ===== rtl/byte_histogram_with_column_readout.sv =====
// Byte histogram with column-major readout: top level.
// Depends on bh_pkg and byte_histogram_with_column_readout_defines.svh.
`default_nettype none

// Accepts one word per cycle on the slave side. Count words run a read-modify-write on a
// 256-entry counter memory: the read is issued when the word is accepted, the incremented
// value is written in the cycle after, and a forwarding register covers a write that lands
// on the entry being read. Read words pass through stage two and a registered output stage;
// a read past the end of the readout yields no result. The input stalls only while a read
// result is waiting and the output register is still held by the sink. Clear words drop the
// per-entry valid bits together, so there is no clearing pass after reset or after a clear.
module byte_histogram_with_column_readout #(
    parameter int COUNT_WIDTH = bh_pkg::COUNT_WIDTH_DEF,
    parameter int COLUMNS     = bh_pkg::COLUMNS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // Input stream
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire  [bh_pkg::BYTE_W-1:0]     i_s_tdata,   // [7:0] data_byte
    input  wire  [bh_pkg::OP_W-1:0]       i_s_tuser,   // [1:0] opcode
    // Result stream
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    output logic [39:0]                   o_m_tdata,   // [7:0] bin_code, [39:8] bin_count
    output logic                          o_m_tuser,   // [0] row_end
    output logic                          o_m_tlast,   // last bin of the readout
    // Configuration writes
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [bh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [bh_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bh_pkg::*;

    localparam int ROWS_HALF = (HALF_CODES + COLUMNS - 1) / COLUMNS;
    localparam int ROWS_ALL  = (NUM_CODES + COLUMNS - 1) / COLUMNS;
    localparam int ROW_W     = $clog2(ROWS_ALL);
    localparam int RCNT_W    = ROW_W + 1;
    localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CODE_W    = 10;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration
    logic [1:0] r_range_mode;
    logic       r_table_mode;

    // Readout position
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_fin, n_fin;

    // Counter memory and its valid bits
    logic [COUNT_WIDTH-1:0] mem [NUM_CODES];
    logic [NUM_CODES-1:0]   r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    // Second stage
    t_kind             r_s1_kind;
    logic [BYTE_W-1:0] r_s1_addr;
    logic              r_s1_row_end;
    logic              r_s1_last;
    logic              r_s1_table;

    // Write seen at the edge the stage-two word was read
    logic                   r_fwd_en;
    logic                   r_fwd_clr;
    logic [BYTE_W-1:0]      r_fwd_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    // Output register
    logic                   r_out_vld;
    logic [BYTE_W-1:0]      r_out_code;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic                   r_out_row_end;
    logic                   r_out_last;

    // Combinational
    logic                   w_out_free;
    logic                   w_s1_adv;
    logic                   w_acc;
    logic [RCNT_W-1:0]      w_rows;
    logic [CODE_W-1:0]      w_lo;
    logic [CODE_W-1:0]      w_hi;
    logic [CODE_W-1:0]      w_code;
    logic [CODE_W-1:0]      w_next_code;
    logic                   w_hit;
    logic                   w_row_end;
    logic                   w_last;
    logic [BYTE_W-1:0]      w_rd_addr;
    t_kind                  w_kind;
    logic [COUNT_WIDTH-1:0] w_cur;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_wr_en;
    logic                   w_clr;
    logic [OUT_COUNT_W-1:0] w_sat;

    // Handshake
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_vld || i_m_tready;
    assign w_s1_adv    = (r_s1_kind != KIND_READ) || w_out_free;
    assign o_s_tready  = w_s1_adv;
    assign w_acc       = i_s_tvalid && o_s_tready;

    // Range geometry and the bin at the current position
    always_comb begin
        w_lo   = '0;
        w_hi   = CODE_W'(NUM_CODES);
        w_rows = RCNT_W'(ROWS_ALL);
        if (r_range_mode == RANGE_LOW) begin
            w_hi   = CODE_W'(HALF_CODES);
            w_rows = RCNT_W'(ROWS_HALF);
        end else if (r_range_mode == RANGE_HIGH) begin
            w_lo   = CODE_W'(HALF_CODES);
            w_rows = RCNT_W'(ROWS_HALF);
        end
        w_code      = w_lo + CODE_W'(r_row) + CODE_W'(r_col) * CODE_W'(w_rows);
        w_next_code = w_code + CODE_W'(w_rows);
        w_hit       = !r_fin
                      && (RCNT_W'(r_row) < w_rows)
                      && ((COL_W + 1)'(r_col) < (COL_W + 1)'(COLUMNS))
                      && (w_code < w_hi);
        w_row_end   = (w_next_code >= w_hi)
                      || ((COL_W + 1)'(r_col) + 1'b1 >= (COL_W + 1)'(COLUMNS));
        w_last      = w_row_end && (RCNT_W'(r_row) + 1'b1 >= w_rows);
    end

    // Decode of the accepted word and readout stepping
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_fin     = r_fin;
        w_kind    = KIND_NONE;
        w_rd_addr = i_s_tdata;
        case (i_s_tuser)
            OP_COUNT: begin
                w_kind = KIND_COUNT;
            end
            OP_READ: begin
                w_rd_addr = w_code[BYTE_W-1:0];
                if (!w_hit) begin
                    n_fin = 1'b1;
                end else begin
                    w_kind = KIND_READ;
                    if (w_last) begin
                        n_fin = 1'b1;
                    end else if (w_row_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                w_kind = KIND_CLEAR;
                n_row  = '0;
                n_col  = '0;
                n_fin  = 1'b0;
            end
            default: begin
                w_kind = KIND_NONE;
            end
        endcase
    end

    // Stage two: current count with forwarding, increment and saturation
    always_comb begin
        if (r_fwd_clr) begin
            w_cur = '0;
        end else if (r_fwd_en && (r_fwd_addr == r_s1_addr)) begin
            w_cur = r_fwd_data;
        end else if (r_rd_vld) begin
            w_cur = r_rd_data;
        end else begin
            w_cur = '0;
        end
        w_inc   = (w_cur == COUNT_MAX) ? w_cur : w_cur + 1'b1;
        w_wr_en = (r_s1_kind == KIND_COUNT);
        w_clr   = (r_s1_kind == KIND_CLEAR);
    end

    // Reported count, clipped to 32 bits
    generate
        if (COUNT_WIDTH > OUT_COUNT_W) begin : g_clip
            assign w_sat = (|w_cur[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1 : w_cur[OUT_COUNT_W-1:0];
        end else begin : g_ext
            assign w_sat = OUT_COUNT_W'(w_cur);
        end
    endgenerate

    // Counter memory: read on accept, write from stage two
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_data <= mem[w_rd_addr];
        end
        if (w_wr_en) begin
            mem[r_s1_addr] <= w_inc;
        end
    end

    // Valid bits: a clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_clr) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[r_s1_addr] <= 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_mode <= '0;
            r_table_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RANGE_MODE: r_range_mode <= i_cfg_data;
                CFG_TABLE_MODE: r_table_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Readout position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_fin <= 1'b0;
        end else if (w_acc) begin
            r_row <= n_row;
            r_col <= n_col;
            r_fin <= n_fin;
        end
    end

    // Stage two control and forwarding record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_kind <= KIND_NONE;
            r_fwd_en  <= 1'b0;
            r_fwd_clr <= 1'b0;
        end else if (w_acc) begin
            r_s1_kind <= w_kind;
            r_fwd_en  <= w_wr_en;
            r_fwd_clr <= w_clr;
        end else if (w_s1_adv) begin
            r_s1_kind <= KIND_NONE;
        end
    end

    // Stage two payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_addr    <= w_rd_addr;
            r_s1_row_end <= w_row_end;
            r_s1_last    <= w_last;
            r_s1_table   <= r_table_mode;
            r_rd_vld     <= r_valid[w_rd_addr];
            r_fwd_addr   <= r_s1_addr;
            r_fwd_data   <= w_inc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= (r_s1_kind == KIND_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && (r_s1_kind == KIND_READ)) begin
            r_out_code    <= r_s1_addr;
            r_out_count   <= r_s1_table ? OUT_COUNT_W'(r_s1_addr) : w_sat;
            r_out_row_end <= r_s1_row_end;
            r_out_last    <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_count, r_out_code};
    assign o_m_tuser  = r_out_row_end;
    assign o_m_tlast  = r_out_last;

    // Checks
    `include "byte_histogram_with_column_readout_defines.svh"

    `BH_ASSERT_SAME(a_stall_on_held_result, (r_s1_kind == KIND_READ) && r_out_vld && !i_m_tready, !o_s_tready, "input taken while a read result is blocked")
    `BH_ASSERT_NEXT(a_clear_rewinds, w_acc && (i_s_tuser == OP_CLEAR), (r_row == '0) && (r_col == '0) && !r_fin, "clear did not rewind readout")
    `BH_ASSERT_NEXT(a_count_sets_valid, w_wr_en, r_valid[$past(r_s1_addr)], "counted entry not marked valid")

endmodule

`default_nettype wire
